@@ rtl/b32d_pkg.sv @@
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types and constants for the base32 digest decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b32d_pkg;

   localparam int DIGEST_BYTES = 20;
   localparam int POS_W        = 5;

   localparam logic [POS_W-1:0] DIGEST_COUNT = POS_W'(DIGEST_BYTES);
   localparam logic [POS_W-1:0] LAST_POS     = POS_W'(DIGEST_BYTES - 1);

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_2 = 8'h32;
   localparam logic [7:0] CHAR_DIGIT_7 = 8'h37;
   localparam logic [7:0] DIGIT_OFFSET = 8'h1A;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic [POS_W-1:0] out_position;
      logic             final_byte;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] value;
   } digit_type;

endpackage

`default_nettype wire

@@ rtl/b32d_lookup.sv @@
// ----------------------------------------------------------------------------
// b32d_lookup
// Maps one character to its base32 digit; flags characters outside the set.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_lookup (
   input  wire logic [7:0]          char_code,
   output b32d_pkg::digit_type      digit
);
   import b32d_pkg::*;

   always_comb begin
      digit.hit   = 1'b0;
      digit.value = 5'd0;
      if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_Z) begin
         digit.hit   = 1'b1;
         digit.value = 5'(char_code - CHAR_UPPER_A);
      end else if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) begin
         digit.hit   = 1'b1;
         digit.value = 5'(char_code - CHAR_LOWER_A);
      end else if (char_code >= CHAR_DIGIT_2 && char_code <= CHAR_DIGIT_7) begin
         digit.hit   = 1'b1;
         digit.value = 5'(char_code - CHAR_DIGIT_2 + DIGIT_OFFSET);
      end
   end

endmodule

`default_nettype wire

@@ rtl/b32d_packer.sv @@
// ----------------------------------------------------------------------------
// b32d_packer
// Packs digits MSB-first into bytes, runs the end-of-string pad sequence and
// holds the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_packer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire logic                item_last,
   input  b32d_pkg::digit_type      digit,
   output logic                     item_take,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output b32d_pkg::rsp_type        rsp_data
);
   import b32d_pkg::*;

   logic [2:0]       bit_pos_ff, bit_pos_in;
   logic [7:0]       partial_ff, partial_in;
   logic [POS_W-1:0] done_ff, done_in;
   logic             flush_ff, flush_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;

   logic             out_free;
   logic [3:0]       total;
   logic [12:0]      wide;

   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      item_take    = item_valid && out_free && !flush_ff;
      total        = {1'b0, bit_pos_ff} + 4'd5;
      wide         = {digit.value, 8'h00} >> total[2:0];

      bit_pos_in   = bit_pos_ff;
      partial_in   = partial_ff;
      done_in      = done_ff;
      flush_in     = flush_ff;
      out_valid_in = out_free ? 1'b0 : out_valid_ff;
      out_data_in  = out_data_ff;

      if (item_take) begin
         if (digit.hit && done_ff < DIGEST_COUNT) begin
            if (total[3]) begin
               out_valid_in             = 1'b1;
               out_data_in.out_byte     = partial_ff | {3'b000, wide[12:8]};
               out_data_in.out_position = done_ff;
               out_data_in.final_byte   = (done_ff == LAST_POS);
               done_in                  = done_ff + POS_W'(1);
               partial_in               = wide[7:0];
               bit_pos_in               = total[2:0];
               if (done_ff == LAST_POS) begin
                  partial_in = 8'h00;
                  bit_pos_in = 3'd0;
               end
            end else begin
               partial_in = partial_ff | ({3'b000, digit.value} << (3'd3 - bit_pos_ff));
               bit_pos_in = total[2:0];
            end
         end
         if (item_last) begin
            if (done_in < DIGEST_COUNT) begin
               flush_in = 1'b1;
            end else begin
               bit_pos_in = 3'd0;
               partial_in = 8'h00;
               done_in    = '0;
            end
         end
      end else if (flush_ff && out_free) begin
         out_valid_in             = 1'b1;
         out_data_in.out_byte     = partial_ff;
         out_data_in.out_position = done_ff;
         out_data_in.final_byte   = (done_ff == LAST_POS);
         partial_in               = 8'h00;
         done_in                  = done_ff + POS_W'(1);
         if (done_ff == LAST_POS) begin
            flush_in   = 1'b0;
            done_in    = '0;
            bit_pos_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_pos_ff   <= 3'd0;
         partial_ff   <= 8'h00;
         done_ff      <= '0;
         flush_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         bit_pos_ff   <= bit_pos_in;
         partial_ff   <= partial_in;
         done_ff      <= done_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

@@ rtl/base32_to_20byte_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// base32_to_20byte_decoder_unit
// Base32 digest decoder: one character per word in, digest bytes out.
// A byte completed by a character passes the input register, then the output
// register. Throughput while rsp_stall is low: 1 character per cycle; a last
// character pads one byte per cycle to digest length, input stalled meanwhile.
// Reset: synchronous, clears the packer state, pad sequence and both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module base32_to_20byte_decoder_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  b32d_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output b32d_pkg::rsp_type        rsp_data
);
   import b32d_pkg::*;

   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff, in_data_in;
   logic      item_take;
   digit_type digit;

   always_comb begin
      in_valid_in = in_valid_ff && !item_take;
      in_data_in  = in_data_ff;
      if (!req_stall && req_valid) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   assign req_stall = in_valid_ff && !item_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
   end

   b32d_lookup u_lookup (
      .char_code (in_data_ff.char_code),
      .digit     (digit)
   );

   b32d_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item_last  (in_data_ff.last_char),
      .digit      (digit),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/b32d_checker.sv @@
// ----------------------------------------------------------------------------
// b32d_checker
// Port-level checks for the base32 digest decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_checker (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  b32d_pkg::req_type        req_data,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  b32d_pkg::rsp_type        rsp_data
);
   import b32d_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out_position < DIGEST_COUNT)
      else $error("byte position beyond digest");

   a_final_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.final_byte == (rsp_data.out_position == LAST_POS))
      else $error("final flag does not match position");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs active after reset");

endmodule

bind base32_to_20byte_decoder_unit b32d_checker u_b32d_checker (.*);

`default_nettype wire
